### design/fdf_pkg.sv
// shared types and constants for the direct-form fir filter
package fdf_pkg;
	localparam int unsigned DATA_W = 16;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned FRAC_W = 15;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEFF  = 1'b1;

	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] sample_in;
		logic        [IDX_W-1:0]  tap_index;
		logic signed [DATA_W-1:0] tap_value;
	} fdf_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_out;
		logic                     clipped;
	} fdf_out_t;

	typedef struct packed {
		logic clr;
		logic issue;
	} mac_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} fdf_state_t;
endpackage

### design/fdf_mac.sv
// shared multiply-accumulate unit, one tap product per cycle
module fdf_mac import fdf_pkg::*; #(
	parameter int unsigned ACC_W = 38
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	output logic signed [ACC_W-1:0]  acc
);
	logic signed [2*DATA_W-1:0] prod_s1;
	logic                       valid_s1;
	logic signed [ACC_W-1:0]    acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;
endmodule

### design/fir_filter_direct_form_core.sv
// top level of the direct-form fir filter with a rotating tap ring
// usage:
// - in channel (in_valid/in_ready/in_data) takes one transaction at a time:
//   op 0 pushes a sample, op 1 writes one coefficient (index >= TAPS ignored)
// - a coefficient write produces no result
// - a sample runs through the single 16x16 multiplier while the delay and
//   weight rings rotate one tap per cycle in the run state; the drain state
//   empties the product register, and the final state rounds, saturates and
//   loads the output register, raising out_valid; the block returns to idle
//   in that same cycle, so a new sample is accepted only once the previous
//   one has left the final state
// - the rings rotate a full turn per sample, so they are back at home
//   position whenever the block is idle
// - out channel (out_valid/out_ready/out_data) carries sample_out and clipped
//   from an output register; the next transaction is accepted while a result
//   is still waiting there
// - if the receiver stalls, a finished sum waits in the final state until
//   the output register is free; in_ready stays low meanwhile
// - reset clears the delay line, all weights and the control state
// - rounding is half up from Q30 to Q15, then saturation to 16 bits
module fir_filter_direct_form_core import fdf_pkg::*; #(
	parameter int unsigned TAPS = 51
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  fdf_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output fdf_out_t out_data
);
	localparam int unsigned CNT_W = $clog2(TAPS);
	localparam int unsigned ACC_W = 2 * DATA_W + CNT_W + 1;

	fdf_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic signed [DATA_W-1:0] dly_q [TAPS];
	logic signed [DATA_W-1:0] wgt_q [TAPS];
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W:0] rnd_sum;
	logic signed [ACC_W-FRAC_W:0] rnd_q15;
	logic out_valid_q;
	fdf_out_t out_q;
	fdf_out_t res;
	mac_ctl_t mac_ctl;
	logic accept, take_sample, take_coeff, last_tap, out_free, rotate;

	assign accept      = in_valid && in_ready;
	assign take_sample = accept && (in_data.op == OP_SAMPLE);
	assign take_coeff  = accept && (in_data.op == OP_COEFF)
		&& ({1'b0, in_data.tap_index} < (IDX_W+1)'(TAPS));
	assign last_tap    = (cnt_q == CNT_W'(TAPS - 1));
	assign out_free    = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (take_sample) state_d = ST_RUN;
			ST_RUN:   if (last_tap) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready      = 1'b0;
		rotate        = 1'b0;
		mac_ctl.clr   = 1'b0;
		mac_ctl.issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				mac_ctl.clr = take_sample;
			end
			ST_RUN: begin
				rotate        = 1'b1;
				mac_ctl.issue = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rotate) begin
				cnt_q <= last_tap ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// delay and weight rings: shift in on a sample, write a weight on a coefficient, rotate during the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				dly_q[i] <= '0;
				wgt_q[i] <= '0;
			end
		end else if (take_sample) begin
			dly_q[0] <= in_data.sample_in;
			for (int i = 1; i < TAPS; i++) dly_q[i] <= dly_q[i-1];
		end else if (take_coeff) begin
			wgt_q[in_data.tap_index[CNT_W-1:0]] <= in_data.tap_value;
		end else if (rotate) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				dly_q[i] <= dly_q[i+1];
				wgt_q[i] <= wgt_q[i+1];
			end
			dly_q[TAPS-1] <= dly_q[0];
			wgt_q[TAPS-1] <= wgt_q[0];
		end
	end

	fdf_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (dly_q[0]),
		.b      (wgt_q[0]),
		.acc    (acc)
	);

	// round half up, floor shift, then saturate
	assign rnd_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_W - 1));
	assign rnd_q15 = rnd_sum[ACC_W:FRAC_W];

	always_comb begin
		if (rnd_q15 > (ACC_W-FRAC_W+1)'(32767)) begin
			res.sample_out = 16'sh7fff;
			res.clipped    = 1'b1;
		end else if (rnd_q15 < -(ACC_W-FRAC_W+1)'(32768)) begin
			res.sample_out = 16'sh8000;
			res.clipped    = 1'b1;
		end else begin
			res.sample_out = rnd_q15[DATA_W-1:0];
			res.clipped    = 1'b0;
		end
	end

	// output register decouples the receiver from the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// no new transaction while the sum is in flight
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input accepted while a sum is in flight");

	// ring is back home when the sum finishes
	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (cnt_q == '0))
		else $error("tap counter not at home after a full rotation");

	// a finished sum lands in the output register
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not delivered to output register");
endmodule
